>>> src/spc_pkg.sv
// spc_pkg: shared constants and controller/datapath interface types for the
// sieve prime counter. No dependencies.
package spc_pkg;

  localparam int unsigned MAX_LIMIT = 65535;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned NUM_W     = $clog2(MAX_LIMIT + 1);
  localparam int unsigned MEM_DEPTH = MAX_LIMIT + 1;
  localparam int unsigned CMP_W     = (NUM_W > LIMIT_W) ? NUM_W : LIMIT_W;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch limit, clear tally, candidate := 2
    logic clr_step;   // clear mark at candidate, candidate += 1
    logic scan_init;  // candidate := 2
    logic count;      // tally += 1 (saturating), multiple := 2 * candidate
    logic mark;       // set mark at multiple, multiple += candidate
    logic next;       // candidate += 1
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic below_two;  // limit below two
    logic cand_last;  // candidate == limit
    logic marked;     // registered mark read at candidate
    logic mult_over;  // multiple > limit
  } status_t;

endpackage

>>> src/spc_datapath.sv
// spc_datapath: limit, candidate, multiple and tally registers plus the
// one-bit-per-number mark memory. Depends on spc_pkg.
module spc_datapath import spc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic [LIMIT_W-1:0] limit_i,
  output status_t            status_o,
  output logic [COUNT_W-1:0] prime_count_o
);

  logic [NUM_W-1:0]   n_q;
  logic [NUM_W-1:0]   cand_q;
  logic [NUM_W:0]     mult_q;
  logic [COUNT_W-1:0] tally_q;
  logic               rdata_q;

  logic               mem [MEM_DEPTH];

  logic [CMP_W-1:0]   limit_ext;
  logic [NUM_W-1:0]   n_sat;
  logic               wr_en;
  logic [NUM_W-1:0]   wr_addr;
  logic               wr_data;

  // saturate the limit to the largest handled value
  always_comb begin
    limit_ext = CMP_W'(limit_i);
    if (limit_ext > CMP_W'(MAX_LIMIT)) begin
      n_sat = NUM_W'(MAX_LIMIT);
    end else begin
      n_sat = NUM_W'(limit_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= '0;
      cand_q  <= '0;
      mult_q  <= '0;
      tally_q <= '0;
    end else begin
      if (cmd_i.load) begin
        n_q     <= n_sat;
        tally_q <= '0;
      end
      if (cmd_i.load || cmd_i.scan_init) begin
        cand_q <= NUM_W'(2);
      end else if (cmd_i.clr_step || cmd_i.next) begin
        cand_q <= cand_q + NUM_W'(1);
      end
      if (cmd_i.count) begin
        mult_q <= {cand_q, 1'b0};
        if (tally_q != COUNT_MAX) begin
          tally_q <= tally_q + COUNT_W'(1);
        end
      end else if (cmd_i.mark) begin
        mult_q <= mult_q + {1'b0, cand_q};
      end
    end
  end

  // single write port: clearing sweep writes 0, marking writes 1
  always_comb begin
    wr_en   = cmd_i.clr_step || cmd_i.mark;
    wr_addr = cmd_i.mark ? mult_q[NUM_W-1:0] : cand_q;
    wr_data = cmd_i.mark;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[cand_q];
  end

  assign status_o.below_two = (n_q < NUM_W'(2));
  assign status_o.cand_last = (cand_q == n_q);
  assign status_o.marked    = rdata_q;
  assign status_o.mult_over = (mult_q > {1'b0, n_q});
  assign prime_count_o      = tally_q;

endmodule

>>> src/spc_ctrl.sv
// spc_ctrl: sequencing state machine for the sieve (clear, scan, mark).
// Depends on spc_pkg.
module spc_ctrl import spc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy,
  output logic    done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_CHECK,
    ST_MARK
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (status_i.below_two) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.clr_step = 1'b1;
          if (status_i.cand_last) begin
            cmd_o.scan_init = 1'b1;
            state_d         = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status_i.marked) begin
          cmd_o.count = 1'b1;
          state_d     = ST_MARK;
        end else if (status_i.cand_last) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.next = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_MARK: begin
        if (!status_i.mult_over) begin
          cmd_o.mark = 1'b1;
        end else if (status_i.cand_last) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.next = 1'b1;
          state_d    = ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

  // result strobe only once the machine is back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy)
    else $error("result strobe while busy");

  // an accepted item always starts work
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not start");

  // strobe only follows a finishing state
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) == ST_CLEAR || $past(state_q) == ST_CHECK
                || $past(state_q) == ST_MARK))
    else $error("result strobe from unexpected state");

  // marking never writes past the limit
  a_mark_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mark |-> !status_i.mult_over)
    else $error("mark beyond limit");

endmodule

>>> src/sieve_prime_counter.sv
// sieve_prime_counter: primes in 2..n by sieve of Eratosthenes, one request a time.
// For limit n >= 2 the run time is set by the mark-memory writes (clear sweep and
// marking) and the candidate reads of the scan. Limits below two skip both.
// One request at a time: busy is high from the accepting edge until the result
// strobe. Reset (rst_ni, async) returns the controller to idle; the mark memory
// is swept clear (2..n) by each request with a limit of two or more.
module sieve_prime_counter import spc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [LIMIT_W-1:0] limit_i,
  output logic               busy,
  output logic               done_o,
  output logic [COUNT_W-1:0] prime_count_o
);

  // Flow per item:
  //   clear sweep  : marks 2..n zeroed, one per cycle
  //   scan         : read mark of candidate, check it next cycle
  //   mark         : for each unmarked candidate, count it and set marks at
  //                  2c, 3c, ... <= n, one per cycle
  // The result stays on prime_count_o for the strobe cycle; the receiver
  // cannot stall, so no output buffering is needed.

  cmd_t    cmd;
  status_t status;

  spc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  spc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .limit_i       (limit_i),
    .status_o      (status),
    .prime_count_o (prime_count_o)
  );

endmodule

>>> sim/tb.sv
// tb: self-checking bench for sieve_prime_counter, directed table then random limits.
// Depends on spc_pkg (widths, MAX_LIMIT, COUNT_MAX) and the sieve_prime_counter RTL.
module tb;
  import spc_pkg::*;

  localparam int unsigned DIR_ROWS   = 25;
  localparam int unsigned RAND_ITEMS = 76;
  localparam int unsigned CYCLE_CAP  = 30000000;
  localparam int unsigned DRAIN_WAIT = 16;

  // one row of the directed table; known = 1 means the count is typed in below
  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic               known;
    logic [COUNT_W-1:0] count;
  } limit_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic [LIMIT_W-1:0] limit_i;
  logic               busy;
  logic               done_o;
  logic [COUNT_W-1:0] prime_count_o;

  logic [COUNT_W-1:0] pending_counts[$];  // counts owed by the block, oldest first
  bit                 sieve_marks[MEM_DEPTH];
  int unsigned        mismatches = 0;
  int unsigned        cycle_count = 0;

  // below two, the smallest primes, powers of two and their neighbors, with the
  // full range once, partway through the table
  limit_row_t directed_rows[DIR_ROWS] = '{
    '{16'd0,     1'b1, 13'd0},
    '{16'd1,     1'b1, 13'd0},
    '{16'd2,     1'b1, 13'd1},
    '{16'd3,     1'b1, 13'd2},
    '{16'd4,     1'b0, 13'd0},
    '{16'd5,     1'b0, 13'd0},
    '{16'd6,     1'b0, 13'd0},
    '{16'd7,     1'b0, 13'd0},
    '{16'd8,     1'b0, 13'd0},
    '{16'd9,     1'b0, 13'd0},
    '{16'd11,    1'b0, 13'd0},
    '{16'd15,    1'b0, 13'd0},
    '{16'd16,    1'b0, 13'd0},
    '{16'd17,    1'b0, 13'd0},
    '{16'd31,    1'b0, 13'd0},
    '{16'd32,    1'b0, 13'd0},
    '{16'd97,    1'b0, 13'd0},
    '{16'd127,   1'b0, 13'd0},
    '{16'd128,   1'b0, 13'd0},
    '{16'd65535, 1'b1, 13'd6542},
    '{16'd1,     1'b1, 13'd0},
    '{16'd255,   1'b0, 13'd0},
    '{16'd256,   1'b0, 13'd0},
    '{16'd257,   1'b0, 13'd0},
    '{16'd1024,  1'b0, 13'd0}
  };

  sieve_prime_counter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .limit_i      (limit_i),
    .busy         (busy),
    .done_o       (done_o),
    .prime_count_o(prime_count_o)
  );

  always #6 clk_i = ~clk_i;

  // Sieve of Eratosthenes over 2..n, n clamped to MAX_LIMIT, tally saturating.
  function automatic logic [COUNT_W-1:0] primes_upto(input logic [LIMIT_W-1:0] lim);
    int unsigned        n;
    int unsigned        cand;
    int unsigned        mult;
    int unsigned        idx;
    logic [COUNT_W-1:0] tally;
    n = 32'(lim);
    if (n > MAX_LIMIT) n = MAX_LIMIT;
    tally = '0;
    for (idx = 0; idx <= n; idx++) sieve_marks[idx] = 1'b0;
    for (cand = 2; cand <= n; cand++) begin
      if (!sieve_marks[cand]) begin
        if (tally != COUNT_MAX) tally++;
        for (mult = 2 * cand; mult <= n; mult += cand) sieve_marks[mult] = 1'b1;
      end
    end
    return tally;
  endfunction

  // Raise start with the limit, hold it until an edge sees busy low, then log the
  // count owed. Returns at the accepting edge with start still high.
  task automatic issue_request(input logic [LIMIT_W-1:0] lim,
                               input logic [COUNT_W-1:0] owed);
    start   <= 1'b1;
    limit_i <= lim;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_counts.push_back(owed);
  endtask

  // Drop start for a random number of cycles; idle_pct is the chance per cycle.
  task automatic sender_gap(input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // result checker: done_o is a one-cycle strobe, sampled at the edge ending it
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_counts.size() == 0) begin
        $error("prime_count: unexpected result %0d with nothing pending", prime_count_o);
        mismatches++;
      end else begin
        if (prime_count_o !== pending_counts[0]) begin
          $error("prime_count: expected %0d, actual %0d", pending_counts[0], prime_count_o);
          mismatches++;
        end
        void'(pending_counts.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned        phase_idle[4];
    int unsigned        item;
    int unsigned        pick;
    logic [LIMIT_W-1:0] lim;
    phase_idle  = '{0, 71, 0, 30};
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    limit_i     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, back to back
    for (item = 0; item < DIR_ROWS; item++) begin
      lim = directed_rows[item].limit;
      issue_request(lim, directed_rows[item].known ? directed_rows[item].count
                                                   : primes_upto(lim));
    end

    // random limits: mostly short sieves, some mid-size, a few large
    for (item = 0; item < RAND_ITEMS; item++) begin
      sender_gap(phase_idle[item / (RAND_ITEMS / 4)]);
      pick = $urandom_range(99);
      if (pick < 10)      lim = LIMIT_W'($urandom_range(3));
      else if (pick < 85) lim = LIMIT_W'($urandom_range(700, 4));
      else if (pick < 97) lim = LIMIT_W'($urandom_range(4095, 701));
      else                lim = LIMIT_W'($urandom_range(16383, 4096));
      issue_request(lim, primes_upto(lim));
    end
    start <= 1'b0;

    while (pending_counts.size() != 0) @(posedge clk_i);
    // catch any stray strobe after the last result
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
src/spc_pkg.sv
src/spc_datapath.sv
src/spc_ctrl.sv
src/sieve_prime_counter.sv
sim/tb.sv
